FILE: design/dsrc_pkg.sv
// Shared constants for the debounced status relay control block.
// Channel and relay bit positions, register indexes and register widths.
// No dependencies.
package dsrc_pkg;

  // Register file
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned THR_W      = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_SHORT_THR = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_THR  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FORCE     = 2'd2;

  localparam logic [THR_W-1:0] SHORT_THR_RST = 8'd10;
  localparam logic [THR_W-1:0] LONG_THR_RST  = 8'd50;

  // Filter channels, also the status flag bits
  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned CH_K1    = 0;
  localparam int unsigned CH_K2    = 1;
  localparam int unsigned CH_K3    = 2;
  localparam int unsigned CH_FAULT = 3;

  // Relay bits
  localparam int unsigned NUM_RELAY = 5;
  localparam int unsigned RL_K2     = 0;
  localparam int unsigned RL_K850   = 1;
  localparam int unsigned RL_K31    = 2;
  localparam int unsigned RL_K32    = 3;
  localparam int unsigned RL_K33    = 4;

  typedef logic [NUM_CH-1:0]    flags_t;
  typedef logic [NUM_RELAY-1:0] relays_t;

endpackage

FILE: design/debounced_status_relay_control.sv
// Debounced status relay control: per-channel on/off tick counters, status
// flags and relay drive, one word in and one word out per tick.
// Depends on dsrc_pkg.
//
//   channel | ports                      | direction | word
//   input   | in_valid / in_ready        | in        | four sampled levels
//   result  | out_valid / out_ready      | out       | four flags, five relays
//   config  | cfg_we, cfg_addr, cfg_wdata| in        | one register write
//
// A word passes through an input register, then the counter update writes the
// flag, relay and counter registers that drive the result ports and sets
// out_valid; one word per cycle sustained while out_ready stays high.
// Synchronous active-low reset clears counters, flags and relays and loads the
// register defaults (short 10, long 50, force off).
// A stalled result holds the state; the input register accepts one more word.
module debounced_status_relay_control #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_k1_level,
  input  logic                               in_k2_level,
  input  logic                               in_k3_level,
  input  logic                               in_fault_level,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_k1_on,
  output logic                               out_k2_on,
  output logic                               out_k3_on,
  output logic                               out_pfc_ok,
  output logic                               out_relay_k2,
  output logic                               out_relay_k850,
  output logic                               out_relay_k31,
  output logic                               out_relay_k32,
  output logic                               out_relay_k33,
  input  logic                               cfg_we,
  input  logic [dsrc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dsrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import dsrc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // Configuration registers
  logic [THR_W-1:0] short_thr_r;
  logic [THR_W-1:0] long_thr_r;
  logic             force_r;

  // Input register
  logic   s1_valid_r;
  flags_t s1_act_r;

  // Filter state, doubles as the result word
  cnt_t    on_cnt_r  [NUM_CH];
  cnt_t    off_cnt_r [NUM_CH];
  cnt_t    on_cnt_nxt  [NUM_CH];
  cnt_t    off_cnt_nxt [NUM_CH];
  flags_t  flags_r;
  flags_t  flags_nxt;
  relays_t relays_r;
  relays_t relays_nxt;
  logic    out_valid_r;

  logic adv;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic reached(input cnt_t v, input logic [THR_W-1:0] thr);
    return CMP_W'(v) >= CMP_W'(thr);
  endfunction

  // Handshake: advance the input word when the result slot is free
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_thr_r <= SHORT_THR_RST;
      long_thr_r  <= LONG_THR_RST;
      force_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SHORT_THR: short_thr_r <= cfg_wdata[THR_W-1:0];
        REG_LONG_THR:  long_thr_r  <= cfg_wdata[THR_W-1:0];
        REG_FORCE:     force_r     <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  // Capture levels as active flags (K1 is active low)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_act_r[CH_K1]    <= ~in_k1_level;
      s1_act_r[CH_K2]    <= in_k2_level;
      s1_act_r[CH_K3]    <= in_k3_level;
      s1_act_r[CH_FAULT] <= in_fault_level;
    end
  end

  // Counter update per channel; K3 uses the long threshold and clears the
  // opposite counter on every tick
  always_comb begin
    cnt_t             inc;
    logic [THR_W-1:0] thr;
    logic             clr;
    flags_nxt = flags_r;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      clr = (ch == CH_K3);
      thr = (ch == CH_K3) ? long_thr_r : short_thr_r;
      on_cnt_nxt[ch]  = on_cnt_r[ch];
      off_cnt_nxt[ch] = off_cnt_r[ch];
      if (s1_act_r[ch]) begin
        inc = sat_inc(on_cnt_r[ch]);
        if (clr) begin
          off_cnt_nxt[ch] = '0;
        end
        if (reached(inc, thr)) begin
          on_cnt_nxt[ch] = '0;
          flags_nxt[ch]  = 1'b1;
        end else begin
          on_cnt_nxt[ch] = inc;
        end
      end else begin
        inc = sat_inc(off_cnt_r[ch]);
        if (clr) begin
          on_cnt_nxt[ch] = '0;
        end
        if (reached(inc, thr)) begin
          off_cnt_nxt[ch] = '0;
          flags_nxt[ch]   = 1'b0;
        end else begin
          off_cnt_nxt[ch] = inc;
        end
      end
    end
  end

  // Relay drive from the new flags
  always_comb begin
    relays_nxt = relays_r;
    if (force_r) begin
      relays_nxt = '1;
    end else if (!flags_nxt[CH_FAULT]) begin
      relays_nxt[RL_K31] = 1'b1;
      relays_nxt[RL_K32] = 1'b1;
    end else begin
      relays_nxt[RL_K2]   = flags_nxt[CH_K2];
      relays_nxt[RL_K850] = flags_nxt[CH_K3];
      relays_nxt[RL_K31]  = flags_nxt[CH_K3];
      relays_nxt[RL_K32]  = flags_nxt[CH_K3];
      relays_nxt[RL_K33]  = flags_nxt[CH_K3];
    end
  end

  // Commit the tick into state and the result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        on_cnt_r[ch]  <= '0;
        off_cnt_r[ch] <= '0;
      end
      flags_r     <= '0;
      relays_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          on_cnt_r[ch]  <= on_cnt_nxt[ch];
          off_cnt_r[ch] <= off_cnt_nxt[ch];
        end
        flags_r     <= flags_nxt;
        relays_r    <= relays_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result ports
  assign out_valid      = out_valid_r;
  assign out_k1_on      = flags_r[CH_K1];
  assign out_k2_on      = flags_r[CH_K2];
  assign out_k3_on      = flags_r[CH_K3];
  assign out_pfc_ok     = flags_r[CH_FAULT];
  assign out_relay_k2   = relays_r[RL_K2];
  assign out_relay_k850 = relays_r[RL_K850];
  assign out_relay_k31  = relays_r[RL_K31];
  assign out_relay_k32  = relays_r[RL_K32];
  assign out_relay_k33  = relays_r[RL_K33];

  // Checks
  a_force_all: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && force_r) |=> (relays_r == '1))
    else $error("force mode did not close all relays");

  a_pfc_low: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !force_r) |=> (flags_r[CH_FAULT] || (relays_r[RL_K31] && relays_r[RL_K32])))
    else $error("K31/K32 open while PFC flag is clear");

  a_k3_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (on_cnt_r[CH_K3] == '0) || (off_cnt_r[CH_K3] == '0))
    else $error("K3 on and off counters both nonzero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(flags_r) && $stable(relays_r)))
    else $error("result state changed while stalled");

endmodule

FILE: tb/tb_debounced_status_relay_control.sv
// Self-checking testbench for debounced_status_relay_control: random and directed ticks,
// a tracker class that predicts each result word, random stalls on both channels.
// Depends on dsrc_pkg and the debounced_status_relay_control RTL.
module tb_debounced_status_relay_control;
  timeunit 1ns;
  timeprecision 1ps;

  import dsrc_pkg::*;

  localparam int unsigned CNT_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic fault_level;
    logic k3_level;
    logic k2_level;
    logic k1_level;
  } levels_t;

  typedef struct packed {
    relays_t relays;
    flags_t  flags;
  } relay_word_t;

  // Track filter counters, flags and relays; hold the words still due from the block
  class relay_word_tracker;
    logic [CNT_W-1:0] on_cnt [NUM_CH];
    logic [CNT_W-1:0] off_cnt [NUM_CH];
    flags_t           flags;
    relays_t          relays;
    logic [THR_W-1:0] short_thr;
    logic [THR_W-1:0] long_thr;
    logic             force_closed;
    relay_word_t      due_words [$];
    int unsigned      errors;

    function new();
      foreach (on_cnt[i]) begin
        on_cnt[i]  = '0;
        off_cnt[i] = '0;
      end
      flags        = '0;
      relays       = '0;
      short_thr    = SHORT_THR_RST;
      long_thr     = LONG_THR_RST;
      force_closed = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_SHORT_THR: short_thr = data[THR_W-1:0];
        REG_LONG_THR:  long_thr = data[THR_W-1:0];
        REG_FORCE:     force_closed = data[0];
        default: ;
      endcase
    endfunction

    // Advance the counter of the sampled level; a count that reaches the threshold
    // clears itself and moves the flag to that level
    function void debounce(int unsigned ch, logic active, logic [THR_W-1:0] thr,
                           bit consecutive);
      logic [CNT_W-1:0] cnt;
      cnt = active ? on_cnt[ch] : off_cnt[ch];
      if (consecutive) begin
        if (active) off_cnt[ch] = '0;
        else        on_cnt[ch] = '0;
      end
      if (cnt != '1) cnt = cnt + 1'b1;
      if (cnt >= thr) begin
        cnt       = '0;
        flags[ch] = active;
      end
      if (active) on_cnt[ch] = cnt;
      else        off_cnt[ch] = cnt;
    endfunction

    function void note_tick(levels_t lv);
      relay_word_t w;
      debounce(CH_K1, !lv.k1_level, short_thr, 1'b0);
      debounce(CH_K2, lv.k2_level, short_thr, 1'b0);
      debounce(CH_K3, lv.k3_level, long_thr, 1'b1);
      debounce(CH_FAULT, lv.fault_level, short_thr, 1'b0);
      if (force_closed) begin
        relays = '1;
      end else if (!flags[CH_FAULT]) begin
        // PFC down: close K31/K32, hold the rest
        relays[RL_K31] = 1'b1;
        relays[RL_K32] = 1'b1;
      end else begin
        relays[RL_K2]   = flags[CH_K2];
        relays[RL_K850] = flags[CH_K3];
        relays[RL_K31]  = flags[CH_K3];
        relays[RL_K32]  = flags[CH_K3];
        relays[RL_K33]  = flags[CH_K3];
      end
      w.flags  = flags;
      w.relays = relays;
      due_words.push_back(w);
    endfunction

    function string field_name(int unsigned i);
      case (i)
        CH_K1:              return "k1_on";
        CH_K2:              return "k2_on";
        CH_K3:              return "k3_on";
        CH_FAULT:           return "pfc_ok";
        NUM_CH + RL_K2:     return "relay_k2";
        NUM_CH + RL_K850:   return "relay_k850";
        NUM_CH + RL_K31:    return "relay_k31";
        NUM_CH + RL_K32:    return "relay_k32";
        NUM_CH + RL_K33:    return "relay_k33";
        default:            return "unknown";
      endcase
    endfunction

    function void check_word(relay_word_t got);
      relay_word_t want;
      if (due_words.size() == 0) begin
        $display("%0t ns: result word with none expected, actual %b", $time, got);
        errors++;
        return;
      end
      want = due_words.pop_front();
      for (int unsigned i = 0; i < NUM_CH + NUM_RELAY; i++) begin
        if (want[i] !== got[i]) begin
          $display("%0t ns: %s expected %0b actual %0b", $time, field_name(i),
                   want[i], got[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_k1_level;
  logic                  in_k2_level;
  logic                  in_k3_level;
  logic                  in_fault_level;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_k1_on;
  logic                  out_k2_on;
  logic                  out_k3_on;
  logic                  out_pfc_ok;
  logic                  out_relay_k2;
  logic                  out_relay_k850;
  logic                  out_relay_k31;
  logic                  out_relay_k32;
  logic                  out_relay_k33;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  relay_word_tracker tracker;
  bit                tx_idle;
  bit                rx_idle;
  bit                hold_req;

  debounced_status_relay_control DUT (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Drive one tick word and hold it until the block takes it
  task automatic send_tick(input levels_t lv);
    in_valid       <= 1'b1;
    in_k1_level    <= lv.k1_level;
    in_k2_level    <= lv.k2_level;
    in_k3_level    <= lv.k3_level;
    in_fault_level <= lv.fault_level;
    do @(posedge clk); while (!in_ready);
    tracker.note_tick(lv);
  endtask

  // Drop valid for a random stretch: mostly none, some short, a few long
  task automatic idle_gap();
    int unsigned r;
    int unsigned gap;
    r   = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every due word is back and the pipeline has emptied
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(addr, data);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] short_v,
                              input logic [CFG_DATA_W-1:0] long_v,
                              input logic [CFG_DATA_W-1:0] force_v,
                              input bit touch_spare);
    wait_idle();
    cfg_write(REG_SHORT_THR, short_v);
    cfg_write(REG_LONG_THR, long_v);
    cfg_write(REG_FORCE, force_v);
    if (touch_spare) cfg_write(REG_SPARE, CFG_DATA_W'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
  endtask

  // Result side: check accepted words, stall at random, honor long hold-off requests
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned r;
    relay_word_t got;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.flags[CH_K1]     = out_k1_on;
        got.flags[CH_K2]     = out_k2_on;
        got.flags[CH_K3]     = out_k3_on;
        got.flags[CH_FAULT]  = out_pfc_ok;
        got.relays[RL_K2]    = out_relay_k2;
        got.relays[RL_K850]  = out_relay_k850;
        got.relays[RL_K31]   = out_relay_k31;
        got.relays[RL_K32]   = out_relay_k32;
        got.relays[RL_K33]   = out_relay_k33;
        tracker.check_word(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 80;
      end else if (stall_left == 0 && rx_idle) begin
        r = $urandom_range(0, 99);
        if (r < 15)      stall_left = $urandom_range(1, 3);
        else if (r < 17) stall_left = $urandom_range(20, 50);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin : tick_source
    levels_t          lv;
    logic [7:0]       s_thr;
    logic [7:0]       l_thr;
    logic [7:0]       f_val;
    int unsigned      flip_div;
    int unsigned      n_items;
    int unsigned      divs [4];
    divs           = '{2, 6, 15, 40};
    tracker        = new();
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    hold_req       = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_k1_level    = 1'b0;
    in_k2_level    = 1'b0;
    in_k3_level    = 1'b0;
    in_fault_level = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    lv             = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a few ticks at the reset thresholds, counts carry over
    send_tick(levels_t'(4'h0));
    send_tick(levels_t'(4'hF));
    send_tick(levels_t'(4'h0));
    send_tick(levels_t'(4'hA));
    // Threshold one: every level combination, PFC down and up
    program_regs(8'd1, 8'd1, 8'h00, 1'b0);
    for (int i = 0; i < 16; i++) send_tick(levels_t'(i[3:0]));
    // Debug force with wide data
    program_regs(8'd1, 8'd1, 8'hFF, 1'b0);
    send_tick(levels_t'(4'h0));
    send_tick(levels_t'(4'h5));
    send_tick(levels_t'(4'hF));
    // Zero thresholds, force bit cleared by its low bit only, spare index poked
    program_regs(8'd0, 8'd0, 8'hFE, 1'b1);
    send_tick(levels_t'(4'h9));
    send_tick(levels_t'(4'h6));
    send_tick(levels_t'(4'h3));

    // Random phases: levels held with a per-phase flip rate
    for (int phase = 0; phase < 8; phase++) begin
      n_items = 50;
      case (phase)
        0: begin
          s_thr = SHORT_THR_RST; l_thr = LONG_THR_RST; f_val = 8'h00; flip_div = 40;
        end
        1: begin
          s_thr = 8'd1; l_thr = 8'd1; f_val = 8'h00; flip_div = 2;
        end
        2: begin
          s_thr = 8'd255; l_thr = 8'd255; f_val = 8'h00; flip_div = 150; n_items = 200;
        end
        3: begin
          s_thr = 8'd3; l_thr = 8'd8; f_val = 8'h01; flip_div = 6;
        end
        default: begin
          s_thr    = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 20));
          l_thr    = 8'($urandom_range(1, 60));
          f_val    = {7'($urandom_range(0, 127)), ($urandom_range(0, 3) == 0)};
          flip_div = divs[$urandom_range(0, 3)];
        end
      endcase
      tx_idle = (phase % 3) != 1;
      rx_idle = (phase % 4) != 1;
      program_regs(s_thr, l_thr, f_val, phase[0]);
      if (phase == 4) begin
        // Stall the result side long enough that the input backs up
        hold_req = 1'b1;
        repeat (24) begin
          for (int b = 0; b < 4; b++) lv[b] = ~lv[b] ^ ($urandom_range(0, 1) == 0);
          send_tick(lv);
        end
      end
      repeat (n_items) begin
        if (tx_idle) idle_gap();
        for (int b = 0; b < 4; b++) begin
          if ($urandom_range(0, flip_div - 1) == 0) lv[b] = ~lv[b];
        end
        send_tick(lv);
      end
    end

    // Drain
    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && tracker.due_words.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.due_words.size() != 0) begin
      $display("%0t ns: %0d result words never arrived", $time, tracker.due_words.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/dsrc_pkg.sv
design/debounced_status_relay_control.sv
tb/tb_debounced_status_relay_control.sv
